FILE: rtl/mwbm_pkg.sv
`default_nettype none
package mwbm_pkg;

  // array sizes and field widths
  localparam int MAX_SIZE     = 32;
  localparam int IDX_W        = 5;
  localparam int CNT_W        = 6;
  localparam int WEIGHT_BITS  = 16;
  localparam int ADDR_W       = 2 * IDX_W;
  localparam int LAB_W        = 32;
  localparam int SLK_W        = LAB_W + 2;
  localparam int SUM_W        = LAB_W + 6;
  localparam int TOTAL_W      = 21;
  localparam int EXTRA_ROUNDS = 11;
  localparam logic [SLK_W-1:0] NO_SLACK = SLK_W'(1) << 30;

  // input operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_SOLVE = 2'd2;

  // configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MAX_RD, ST_MAX_CHK, ST_ROUND, ST_DFS_RD, ST_DFS_CHK,
    ST_UNWIND, ST_FAIL, ST_ADJ_START, ST_ADJ_RD, ST_ADJ_CHK, ST_APPLY,
    ST_ROW_NEXT, ST_SUM, ST_EMIT
  } state_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_CLR_START, DP_CLEAR, DP_WRITE, DP_SOLVE_START, DP_MAX_RD,
    DP_MAX_CHK, DP_ROUND_START, DP_DFS_RD, DP_DFS_CHK, DP_UNWIND, DP_FAIL,
    DP_ADJ_START, DP_ADJ_RD, DP_ADJ_CHK, DP_APPLY, DP_ROW_NEXT, DP_SUM, DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic it_last;
    logic dfs_end;
    logic dfs_skip;
    logic tight;
    logic col_free;
    logic sp_zero;
    logic adj_skip;
    logic round_cap;
    logic root_last;
    logic sum_last;
    logic out_free;
    logic emit_last;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/max_weight_bipartite_matcher_unit.sv
// clear: all 1024 weights are swept to zero; weight writes are taken one per cycle while idle
// solve: label init reads every weight in use for the row maxima, then per round a
// depth-first search and a slack sweep over the weights read from the weight store
// output: one item per column in use once the label sum over all 32 label pairs is done
// reset: synchronous active low; after reset the weight store is swept to zero, all
// 1024 entries, and no input item is taken during the sweep
`default_nettype none
module max_weight_bipartite_matcher_unit
  import mwbm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // fields from bit 0: op[1:0], row[6:2], col[11:7], weight[27:12], zero fill
  input  wire logic [31:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // fields from bit 0: column[4:0], has_match[5], matched_row[10:6], total[31:11]
  output logic [31:0]      out_tdata,
  output logic             out_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [5:0]  cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [IDX_W-1:0]   o_col, o_row;
  logic               o_has;
  logic [TOTAL_W-1:0] o_tot;

  assign cfg_ready = 1'b1;

  // sequencer
  mwbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tdata[1:0]),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and arithmetic
  mwbm_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_row          (in_tdata[6:2]),
    .in_col          (in_tdata[11:7]),
    .in_weight       (in_tdata[27:12]),
    .cfg_we          (cfg_valid),
    .cfg_idx         (cfg_index),
    .cfg_val         (cfg_data),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_column      (o_col),
    .out_has_match   (o_has),
    .out_matched_row (o_row),
    .out_total       (o_tot),
    .out_last        (out_tlast)
  );

  assign out_tdata = {o_tot, o_row, o_has, o_col};

endmodule
`default_nettype wire

FILE: rtl/mwbm_ctrl.sv
`default_nettype none
module mwbm_ctrl
  import mwbm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic [1:0] in_op,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state_r, state_nxt;

  // state register, reset starts the weight clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and datapath command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NOP;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.op = DP_CLEAR;
        if (stat.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_op)
            OP_CLEAR: begin
              cmd.op    = DP_CLR_START;
              state_nxt = ST_CLEAR;
            end
            OP_WRITE: cmd.op = DP_WRITE;
            OP_SOLVE: begin
              cmd.op    = DP_SOLVE_START;
              state_nxt = ST_MAX_RD;
            end
            default: cmd.op = DP_NOP;
          endcase
        end
      end
      ST_MAX_RD: begin
        cmd.op    = DP_MAX_RD;
        state_nxt = ST_MAX_CHK;
      end
      ST_MAX_CHK: begin
        cmd.op    = DP_MAX_CHK;
        state_nxt = stat.it_last ? ST_ROUND : ST_MAX_RD;
      end
      ST_ROUND: begin
        cmd.op    = DP_ROUND_START;
        state_nxt = ST_DFS_RD;
      end
      ST_DFS_RD: begin
        cmd.op = DP_DFS_RD;
        priority if (stat.dfs_end) state_nxt = ST_FAIL;
        else if (stat.dfs_skip)    state_nxt = ST_DFS_RD;
        else                       state_nxt = ST_DFS_CHK;
      end
      ST_DFS_CHK: begin
        cmd.op    = DP_DFS_CHK;
        state_nxt = (stat.tight && stat.col_free) ? ST_UNWIND : ST_DFS_RD;
      end
      ST_UNWIND: begin
        cmd.op = DP_UNWIND;
        if (stat.sp_zero) state_nxt = ST_ROW_NEXT;
      end
      ST_FAIL: begin
        cmd.op    = DP_FAIL;
        state_nxt = stat.sp_zero ? ST_ADJ_START : ST_DFS_RD;
      end
      ST_ADJ_START: begin
        cmd.op    = DP_ADJ_START;
        state_nxt = ST_ADJ_RD;
      end
      ST_ADJ_RD: begin
        cmd.op = DP_ADJ_RD;
        priority if (!stat.adj_skip) state_nxt = ST_ADJ_CHK;
        else if (stat.it_last)       state_nxt = ST_APPLY;
        else                         state_nxt = ST_ADJ_RD;
      end
      ST_ADJ_CHK: begin
        cmd.op    = DP_ADJ_CHK;
        state_nxt = stat.it_last ? ST_APPLY : ST_ADJ_RD;
      end
      ST_APPLY: begin
        cmd.op    = DP_APPLY;
        state_nxt = stat.round_cap ? ST_ROW_NEXT : ST_ROUND;
      end
      ST_ROW_NEXT: begin
        cmd.op    = DP_ROW_NEXT;
        state_nxt = stat.root_last ? ST_SUM : ST_ROUND;
      end
      ST_SUM: begin
        cmd.op = DP_SUM;
        if (stat.sum_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.op = DP_EMIT;
          if (stat.emit_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/mwbm_datapath.sv
`default_nettype none
module mwbm_datapath
  import mwbm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire dp_cmd_t                cmd,
  output dp_stat_t                    stat,
  input  wire logic [IDX_W-1:0]       in_row,
  input  wire logic [IDX_W-1:0]       in_col,
  input  wire logic [WEIGHT_BITS-1:0] in_weight,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_idx,
  input  wire logic [CNT_W-1:0]       cfg_val,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [IDX_W-1:0]            out_column,
  output logic                        out_has_match,
  output logic [IDX_W-1:0]            out_matched_row,
  output logic [TOTAL_W-1:0]          out_total,
  output logic                        out_last
);

  localparam int DEPTH = MAX_SIZE * MAX_SIZE;

  // weight store and registered read
  logic [WEIGHT_BITS-1:0] mem [DEPTH];
  logic [WEIGHT_BITS-1:0] rd_r;
  logic [ADDR_W-1:0]      rd_addr, wr_addr, clr_r, clr_nxt;
  logic                   wr_en;
  logic [WEIGHT_BITS-1:0] wr_data;

  // configuration and active sizes
  logic [CNT_W-1:0] rows_cfg_r, cols_cfg_r, act_rows_r, act_cols_r;
  logic [CNT_W-1:0] clamp_rows, clamp_cols;

  // labels, matching and search state
  logic signed [LAB_W-1:0] rl_r [MAX_SIZE];
  logic signed [LAB_W-1:0] cl_r [MAX_SIZE];
  logic [CNT_W-1:0]        owner_r [MAX_SIZE];
  logic [MAX_SIZE-1:0]     rv_r, cv_r;
  logic [ADDR_W-1:0]       stk_r [MAX_SIZE];
  logic [CNT_W-1:0]        sp_r;
  logic [IDX_W-1:0]        sp_m1;
  logic [IDX_W-1:0]        ir_r, ic_r, cr_r, root_r;
  logic [CNT_W-1:0]        cc_r, k_r;
  logic [SLK_W-1:0]        amin_r;
  logic signed [SUM_W-1:0] sum_r;

  // output register
  logic                    ov_r;
  logic [IDX_W-1:0]        o_col_r, o_row_r;
  logic                    o_has_r, o_last_r;
  logic [TOTAL_W-1:0]      o_tot_r;

  // label read port shared by the max, search and slack phases
  logic [IDX_W-1:0]        lr_idx, lc_idx;
  logic signed [LAB_W-1:0] rl_q, cl_q;
  logic signed [SLK_W-1:0] lab_sum, w_ext, slack;
  logic                    dfs_phase;
  logic [IDX_W-1:0]        owner_row;
  logic [TOTAL_W-1:0]      total_sat;

  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v);
    if (v == '0) return CNT_W'(1);
    if (v > CNT_W'(MAX_SIZE)) return CNT_W'(MAX_SIZE);
    return v;
  endfunction

  assign clamp_rows = clamp_cnt(rows_cfg_r);
  assign clamp_cols = (clamp_cnt(cols_cfg_r) < clamp_rows) ? clamp_rows
                                                           : clamp_cnt(cols_cfg_r);

  assign dfs_phase = (cmd.op == DP_DFS_RD) || (cmd.op == DP_DFS_CHK);
  assign lr_idx    = dfs_phase ? cr_r : ir_r;
  assign lc_idx    = dfs_phase ? cc_r[IDX_W-1:0] : ic_r;
  assign rl_q      = rl_r[lr_idx];
  assign cl_q      = cl_r[lc_idx];
  assign lab_sum   = SLK_W'(rl_q) + SLK_W'(cl_q);
  assign w_ext     = $signed({{(SLK_W-WEIGHT_BITS){1'b0}}, rd_r});
  assign slack     = lab_sum - w_ext;
  assign sp_m1     = sp_r[IDX_W-1:0] - IDX_W'(1);
  assign owner_row = owner_r[cc_r[IDX_W-1:0]][IDX_W-1:0] - IDX_W'(1);
  assign rd_addr   = dfs_phase ? {cr_r, cc_r[IDX_W-1:0]} : {ir_r, ic_r};
  assign clr_nxt   = clr_r + ADDR_W'(1);

  // memory port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_r;
    wr_data = '0;
    if (cmd.op == DP_CLEAR) begin
      wr_en = 1'b1;
    end else if (cmd.op == DP_WRITE) begin
      wr_en   = 1'b1;
      wr_addr = {in_row, in_col};
      wr_data = in_weight;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  // total saturation
  always_comb begin
    if (sum_r < 0) total_sat = '0;
    else if (sum_r > SUM_W'((1 << TOTAL_W) - 1)) total_sat = '1;
    else total_sat = sum_r[TOTAL_W-1:0];
  end

  // status back to the controller
  always_comb begin
    stat.clr_done  = (clr_r == '1);
    stat.it_last   = (CNT_W'(ir_r) == act_rows_r - CNT_W'(1)) &&
                     (CNT_W'(ic_r) == act_cols_r - CNT_W'(1));
    stat.dfs_end   = (cc_r == act_cols_r);
    stat.dfs_skip  = cv_r[cc_r[IDX_W-1:0]];
    stat.tight     = (lab_sum == w_ext);
    stat.col_free  = (owner_r[cc_r[IDX_W-1:0]] == '0);
    stat.sp_zero   = (sp_r == '0);
    stat.adj_skip  = cv_r[ic_r] || !rv_r[ir_r];
    stat.round_cap = (k_r >= act_rows_r + CNT_W'(EXTRA_ROUNDS));
    stat.root_last = (CNT_W'(root_r) == act_rows_r - CNT_W'(1));
    stat.sum_last  = (ir_r == '1);
    stat.out_free  = !ov_r || out_ready;
    stat.emit_last = (CNT_W'(ic_r) == act_cols_r - CNT_W'(1));
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= CNT_W'(MAX_SIZE);
      cols_cfg_r <= CNT_W'(MAX_SIZE);
    end else if (cfg_we) begin
      if (cfg_idx == CFG_ROWS) rows_cfg_r <= cfg_val;
      if (cfg_idx == CFG_COLS) cols_cfg_r <= cfg_val;
    end
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.op == DP_CLR_START) begin
      clr_r <= '0;
    end else if (cmd.op == DP_CLEAR) begin
      clr_r <= clr_nxt;
    end
  end

  // output item register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.op == DP_EMIT) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_EMIT) begin
      o_col_r  <= ic_r;
      o_has_r  <= (owner_r[ic_r] != '0);
      o_row_r  <= (owner_r[ic_r] != '0) ? owner_r[ic_r][IDX_W-1:0] - IDX_W'(1) : '0;
      o_last_r <= stat.emit_last;
      o_tot_r  <= stat.emit_last ? total_sat : '0;
    end
  end

  // solver datapath
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_SOLVE_START: begin
        act_rows_r <= clamp_rows;
        act_cols_r <= clamp_cols;
        for (int i = 0; i < MAX_SIZE; i++) begin
          rl_r[i]    <= '0;
          cl_r[i]    <= '0;
          owner_r[i] <= '0;
        end
        ir_r   <= '0;
        ic_r   <= '0;
        root_r <= '0;
        k_r    <= CNT_W'(1);
        sum_r  <= '0;
      end
      DP_MAX_CHK: begin
        if ($signed({{(LAB_W-WEIGHT_BITS){1'b0}}, rd_r}) > rl_q) begin
          rl_r[ir_r] <= $signed({{(LAB_W-WEIGHT_BITS){1'b0}}, rd_r});
        end
        if (CNT_W'(ic_r) == act_cols_r - CNT_W'(1)) begin
          ic_r <= '0;
          ir_r <= ir_r + IDX_W'(1);
        end else begin
          ic_r <= ic_r + IDX_W'(1);
        end
      end
      DP_ROUND_START: begin
        rv_r <= MAX_SIZE'(1) << root_r;
        cv_r <= '0;
        cr_r <= root_r;
        cc_r <= '0;
        sp_r <= '0;
      end
      DP_DFS_RD: begin
        if (!stat.dfs_end && stat.dfs_skip) cc_r <= cc_r + CNT_W'(1);
      end
      DP_DFS_CHK: begin
        if (stat.tight) begin
          cv_r[cc_r[IDX_W-1:0]] <= 1'b1;
          if (!stat.col_free) begin
            stk_r[sp_r[IDX_W-1:0]] <= {cr_r, cc_r[IDX_W-1:0]};
            sp_r                   <= sp_r + CNT_W'(1);
            cr_r                   <= owner_row;
            rv_r[owner_row]        <= 1'b1;
            cc_r                   <= '0;
          end
        end else begin
          cc_r <= cc_r + CNT_W'(1);
        end
      end
      DP_UNWIND: begin
        owner_r[cc_r[IDX_W-1:0]] <= CNT_W'(cr_r) + CNT_W'(1);
        if (!stat.sp_zero) begin
          cr_r <= stk_r[sp_m1][ADDR_W-1:IDX_W];
          cc_r <= CNT_W'(stk_r[sp_m1][IDX_W-1:0]);
          sp_r <= sp_r - CNT_W'(1);
        end
      end
      DP_FAIL: begin
        if (!stat.sp_zero) begin
          cr_r <= stk_r[sp_m1][ADDR_W-1:IDX_W];
          cc_r <= CNT_W'(stk_r[sp_m1][IDX_W-1:0]) + CNT_W'(1);
          sp_r <= sp_r - CNT_W'(1);
        end
      end
      DP_ADJ_START: begin
        amin_r <= NO_SLACK;
        ir_r   <= '0;
        ic_r   <= '0;
      end
      DP_ADJ_RD, DP_ADJ_CHK: begin
        if (cmd.op == DP_ADJ_CHK && $signed(slack) < $signed(amin_r)) amin_r <= slack;
        if (cmd.op == DP_ADJ_CHK || stat.adj_skip) begin
          if (CNT_W'(ir_r) == act_rows_r - CNT_W'(1)) begin
            ir_r <= '0;
            ic_r <= ic_r + IDX_W'(1);
          end else begin
            ir_r <= ir_r + IDX_W'(1);
          end
        end
      end
      DP_APPLY: begin
        for (int i = 0; i < MAX_SIZE; i++) begin
          if (cv_r[i] && (CNT_W'(i) < act_cols_r)) cl_r[i] <= cl_r[i] + amin_r[LAB_W-1:0];
          if (rv_r[i] && (CNT_W'(i) < act_rows_r)) rl_r[i] <= rl_r[i] - amin_r[LAB_W-1:0];
        end
        k_r <= k_r + CNT_W'(1);
      end
      DP_ROW_NEXT: begin
        k_r    <= CNT_W'(1);
        root_r <= root_r + IDX_W'(1);
        ir_r   <= '0;
      end
      DP_SUM: begin
        sum_r <= sum_r + SUM_W'(rl_r[ir_r]) + SUM_W'(cl_r[ir_r]);
        ir_r  <= ir_r + IDX_W'(1);
        ic_r  <= '0;
      end
      DP_EMIT: begin
        ic_r <= ic_r + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign out_valid       = ov_r;
  assign out_column      = o_col_r;
  assign out_has_match   = o_has_r;
  assign out_matched_row = o_row_r;
  assign out_total       = o_tot_r;
  assign out_last        = o_last_r;

endmodule
`default_nettype wire
